/* sv/sqvt_pkg.sv */
`default_nettype none

package sqvt_pkg;

	localparam int SINE_TABLE_DEPTH = 1024;
	localparam int ANGLE_FRAC_W = 14;
	localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int IDX_PROD_W = ANGLE_FRAC_W + IDX_W;
	localparam logic [IDX_W-1:0] SINE_TOP = IDX_W'(SINE_TABLE_DEPTH);
	localparam int SINE_W = 17;
	localparam int TRIG_W = SINE_W + 1;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] Q16_ONE = 64'd65536;
	localparam int CFG_INDEX_W = 1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_CAMERA_X = 1'b0,
		REG_CAMERA_Y = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		QUAD_0 = 2'd0,
		QUAD_1 = 2'd1,
		QUAD_2 = 2'd2,
		QUAD_3 = 2'd3
	} quadrant_t;

	typedef enum logic [1:0] {
		CORNER_BL = 2'd0,
		CORNER_BR = 2'd1,
		CORNER_TR = 2'd2,
		CORNER_TL = 2'd3
	} corner_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
	} camera_t;

	typedef struct packed {
		logic signed [32:0]       vx;
		logic signed [32:0]       vy;
		logic signed [TRIG_W-1:0] sin_v;
		logic signed [TRIG_W-1:0] cos_v;
		logic signed [31:0]       scx;
		logic signed [31:0]       scy;
		logic signed [32:0]       offx;
		logic signed [32:0]       offy;
		logic [31:0]              color;
		corner_t                  corner;
	} corner_req_t;

	// quarter-wave entry, Q2.30 Taylor series to x^15, rounded to Q16
	function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        r;
		x = (64'(i) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
		x2 = (x * x) >> 30;
		term = x;
		sum = $signed(x);
		term = ((term * x2) >> 30) / 64'd6;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd20;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd42;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd72;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd110;
		sum = sum - $signed(term);
		term = ((term * x2) >> 30) / 64'd156;
		sum = sum + $signed(term);
		term = ((term * x2) >> 30) / 64'd210;
		sum = sum - $signed(term);
		if (sum < 64'sd0) begin
			sum = '0;
		end
		r = $unsigned(sum + 64'sd8192) >> 14;
		if (r > Q16_ONE) begin
			r = Q16_ONE;
		end
		if (i == 0) begin
			r = '0;
		end
		if (i == SINE_TABLE_DEPTH) begin
			r = Q16_ONE;
		end
		return r[SINE_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* sv/sqvt_if.sv */
`default_nettype none

interface sqvt_sprite_if import sqvt_pkg::*; ();
	logic        valid;
	logic        ready;
	logic        sprite_enabled;
	logic [30:0] sprite_width;
	logic [30:0] sprite_height;
	logic [16:0] pivot_frac_x;
	logic [16:0] pivot_frac_y;
	logic [15:0] turn_angle;
	logic signed [31:0] scale_x;
	logic signed [31:0] scale_y;
	logic signed [31:0] position_x;
	logic signed [31:0] position_y;
	logic        use_camera;
	logic [31:0] tint_rgba;

	modport source (
		output valid, sprite_enabled, sprite_width, sprite_height, pivot_frac_x,
			pivot_frac_y, turn_angle, scale_x, scale_y, position_x, position_y,
			use_camera, tint_rgba,
		input ready
	);
	modport sink (
		input valid, sprite_enabled, sprite_width, sprite_height, pivot_frac_x,
			pivot_frac_y, turn_angle, scale_x, scale_y, position_x, position_y,
			use_camera, tint_rgba,
		output ready
	);
endinterface

interface sqvt_vertex_if import sqvt_pkg::*; ();
	logic        valid;
	logic        ready;
	logic signed [31:0] vertex_x;
	logic signed [31:0] vertex_y;
	logic        tex_u;
	logic        tex_v;
	logic [31:0] vertex_color;
	logic [1:0]  corner_index;
	logic        last_corner;

	modport source (
		output valid, vertex_x, vertex_y, tex_u, tex_v, vertex_color, corner_index,
			last_corner,
		input ready
	);
	modport sink (
		input valid, vertex_x, vertex_y, tex_u, tex_v, vertex_color, corner_index,
			last_corner,
		output ready
	);
endinterface

interface sqvt_cfg_if import sqvt_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [31:0]            data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* sv/sqvt_sine_rom.sv */
`default_nettype none

module sqvt_sine_rom import sqvt_pkg::*; (
	input  logic                     clk,
	input  logic                     en,
	input  logic [IDX_W-1:0]         idx,
	input  quadrant_t                quad,
	output logic signed [TRIG_W-1:0] sin_q,
	output logic signed [TRIG_W-1:0] cos_q
);

	logic [SINE_W-1:0]        sine_lut [SINE_TABLE_DEPTH+1];
	logic [SINE_W-1:0]        lo;
	logic [SINE_W-1:0]        hi;
	logic signed [TRIG_W-1:0] a;
	logic signed [TRIG_W-1:0] b;

	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_lut
		assign sine_lut[g] = sine_entry(g);
	end

	assign lo = sine_lut[idx];
	assign hi = sine_lut[SINE_TOP - idx];
	assign a  = $signed({1'b0, lo});
	assign b  = $signed({1'b0, hi});

	always_ff @(posedge clk) begin
		if (en) begin
			unique case (quad)
				QUAD_0: begin
					sin_q <= a;
					cos_q <= b;
				end
				QUAD_1: begin
					sin_q <= b;
					cos_q <= -a;
				end
				QUAD_2: begin
					sin_q <= -a;
					cos_q <= -b;
				end
				QUAD_3: begin
					sin_q <= -b;
					cos_q <= a;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/sqvt_sprite_front.sv */
`default_nettype none

module sqvt_sprite_front import sqvt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sqvt_sprite_if.sink sprite,
	input  camera_t     camera,
	output logic        issue_valid,
	input  logic        issue_ready,
	output corner_req_t issue
);

	// stage 1: pivot products, table index, offset
	logic               valid_s1;
	logic [30:0]        w_s1;
	logic [30:0]        h_s1;
	logic [31:0]        px_s1;
	logic [31:0]        py_s1;
	logic [IDX_W-1:0]   idx_s1;
	quadrant_t          quad_s1;
	logic signed [31:0] scx_s1;
	logic signed [31:0] scy_s1;
	logic signed [32:0] offx_s1;
	logic signed [32:0] offy_s1;
	logic [31:0]        color_s1;

	// stage 2: sprite held while its four corners issue
	logic               valid_s2;
	logic signed [32:0] vxn_s2;
	logic signed [32:0] vxp_s2;
	logic signed [32:0] vyn_s2;
	logic signed [32:0] vyp_s2;
	logic signed [TRIG_W-1:0] sin_s2;
	logic signed [TRIG_W-1:0] cos_s2;
	logic signed [31:0] scx_s2;
	logic signed [31:0] scy_s2;
	logic signed [32:0] offx_s2;
	logic signed [32:0] offy_s2;
	logic [31:0]        color_s2;
	corner_t            corner_s2;

	logic [47:0]           px_prod;
	logic [47:0]           py_prod;
	logic [IDX_PROD_W-1:0] idx_prod;
	logic [31:0]           camx_sel;
	logic [31:0]           camy_sel;
	logic                  fire;
	logic                  last;
	logic                  s2_load;
	logic                  s1_take;

	assign fire    = valid_s2 && issue_ready;
	assign last    = (corner_s2 == CORNER_TL);
	assign s2_load = valid_s1 && (!valid_s2 || (fire && last));
	assign s1_take = !valid_s1 || s2_load;

	assign sprite.ready = s1_take;

	assign px_prod  = 48'(sprite.pivot_frac_x) * 48'(sprite.sprite_width);
	assign py_prod  = 48'(sprite.pivot_frac_y) * 48'(sprite.sprite_height);
	assign idx_prod = IDX_PROD_W'(sprite.turn_angle[ANGLE_FRAC_W-1:0])
		* IDX_PROD_W'(SINE_TABLE_DEPTH);
	assign camx_sel = sprite.use_camera ? camera.x : '0;
	assign camy_sel = sprite.use_camera ? camera.y : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_take) begin
			valid_s1 <= sprite.valid && sprite.sprite_enabled;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_take) begin
			w_s1     <= sprite.sprite_width;
			h_s1     <= sprite.sprite_height;
			px_s1    <= px_prod[47:16];
			py_s1    <= py_prod[47:16];
			idx_s1   <= idx_prod[ANGLE_FRAC_W +: IDX_W];
			quad_s1  <= quadrant_t'(sprite.turn_angle[15:14]);
			scx_s1   <= sprite.scale_x;
			scy_s1   <= sprite.scale_y;
			offx_s1  <= $signed({sprite.position_x[31], sprite.position_x})
				- $signed({camx_sel[31], camx_sel});
			offy_s1  <= $signed({sprite.position_y[31], sprite.position_y})
				- $signed({camy_sel[31], camy_sel});
			color_s1 <= sprite.tint_rgba;
		end
	end

	sqvt_sine_rom u_rom (
		.clk   (clk),
		.en    (s2_load),
		.idx   (idx_s1),
		.quad  (quad_s1),
		.sin_q (sin_s2),
		.cos_q (cos_s2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			corner_s2 <= CORNER_BL;
		end else if (s2_load) begin
			valid_s2  <= 1'b1;
			corner_s2 <= CORNER_BL;
		end else if (fire) begin
			valid_s2  <= !last;
			corner_s2 <= corner_t'(corner_s2 + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			vxn_s2   <= 33'sd0 - $signed({1'b0, px_s1});
			vxp_s2   <= $signed({2'b00, w_s1}) - $signed({1'b0, px_s1});
			vyn_s2   <= 33'sd0 - $signed({1'b0, py_s1});
			vyp_s2   <= $signed({2'b00, h_s1}) - $signed({1'b0, py_s1});
			scx_s2   <= scx_s1;
			scy_s2   <= scy_s1;
			offx_s2  <= offx_s1;
			offy_s2  <= offy_s1;
			color_s2 <= color_s1;
		end
	end

	assign issue_valid = valid_s2;

	always_comb begin
		issue.vx     = (corner_s2 == CORNER_BR || corner_s2 == CORNER_TR) ? vxp_s2 : vxn_s2;
		issue.vy     = (corner_s2 == CORNER_TR || corner_s2 == CORNER_TL) ? vyp_s2 : vyn_s2;
		issue.sin_v  = sin_s2;
		issue.cos_v  = cos_s2;
		issue.scx    = scx_s2;
		issue.scy    = scy_s2;
		issue.offx   = offx_s2;
		issue.offy   = offy_s2;
		issue.color  = color_s2;
		issue.corner = corner_s2;
	end

endmodule

`default_nettype wire

/* sv/sqvt_corner_pipe.sv */
`default_nettype none

module sqvt_corner_pipe import sqvt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          issue_valid,
	output logic          issue_ready,
	input  corner_req_t   issue,
	sqvt_vertex_if.source vertex
);

	function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
		logic signed [31:0] r;
		if (v > 49'sh7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -49'sh8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	logic adv;

	// s1: rotation products
	logic               valid_s1;
	logic signed [50:0] xc_s1;
	logic signed [50:0] ys_s1;
	logic signed [50:0] xs_s1;
	logic signed [50:0] yc_s1;
	logic signed [31:0] scx_s1;
	logic signed [31:0] scy_s1;
	logic signed [32:0] offx_s1;
	logic signed [32:0] offy_s1;
	logic [31:0]        color_s1;
	corner_t            corner_s1;

	// s2: rotated corner
	logic               valid_s2;
	logic signed [31:0] rx_s2;
	logic signed [31:0] ry_s2;
	logic signed [31:0] scx_s2;
	logic signed [31:0] scy_s2;
	logic signed [32:0] offx_s2;
	logic signed [32:0] offy_s2;
	logic [31:0]        color_s2;
	corner_t            corner_s2;

	// s3: scale products
	logic               valid_s3;
	logic signed [63:0] mx_s3;
	logic signed [63:0] my_s3;
	logic signed [32:0] offx_s3;
	logic signed [32:0] offy_s3;
	logic [31:0]        color_s3;
	corner_t            corner_s3;

	// s4: output register
	logic               valid_s4;
	logic signed [31:0] x_s4;
	logic signed [31:0] y_s4;
	logic [31:0]        color_s4;
	corner_t            corner_s4;

	logic signed [51:0] rx_wide;
	logic signed [51:0] ry_wide;
	logic signed [48:0] fx_wide;
	logic signed [48:0] fy_wide;

	assign adv         = !valid_s4 || vertex.ready;
	assign issue_ready = adv;

	assign rx_wide = $signed({xc_s1[50], xc_s1}) - $signed({ys_s1[50], ys_s1});
	assign ry_wide = $signed({xs_s1[50], xs_s1}) + $signed({yc_s1[50], yc_s1});
	assign fx_wide = $signed({{16{offx_s3[32]}}, offx_s3}) + $signed({mx_s3[63], mx_s3[63:16]});
	assign fy_wide = $signed({{16{offy_s3[32]}}, offy_s3}) + $signed({my_s3[63], my_s3[63:16]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			xc_s1     <= $signed(issue.vx) * $signed(issue.cos_v);
			ys_s1     <= $signed(issue.vy) * $signed(issue.sin_v);
			xs_s1     <= $signed(issue.vx) * $signed(issue.sin_v);
			yc_s1     <= $signed(issue.vy) * $signed(issue.cos_v);
			scx_s1    <= issue.scx;
			scy_s1    <= issue.scy;
			offx_s1   <= issue.offx;
			offy_s1   <= issue.offy;
			color_s1  <= issue.color;
			corner_s1 <= issue.corner;

			rx_s2     <= sat32({{13{rx_wide[51]}}, rx_wide[51:16]});
			ry_s2     <= sat32({{13{ry_wide[51]}}, ry_wide[51:16]});
			scx_s2    <= scx_s1;
			scy_s2    <= scy_s1;
			offx_s2   <= offx_s1;
			offy_s2   <= offy_s1;
			color_s2  <= color_s1;
			corner_s2 <= corner_s1;

			mx_s3     <= $signed(rx_s2) * $signed(scx_s2);
			my_s3     <= $signed(ry_s2) * $signed(scy_s2);
			offx_s3   <= offx_s2;
			offy_s3   <= offy_s2;
			color_s3  <= color_s2;
			corner_s3 <= corner_s2;

			x_s4      <= sat32(fx_wide);
			y_s4      <= sat32(fy_wide);
			color_s4  <= color_s3;
			corner_s4 <= corner_s3;
		end
	end

	assign vertex.valid        = valid_s4;
	assign vertex.vertex_x     = x_s4;
	assign vertex.vertex_y     = y_s4;
	assign vertex.tex_u        = (corner_s4 == CORNER_BR) || (corner_s4 == CORNER_TR);
	assign vertex.tex_v        = (corner_s4 == CORNER_BL) || (corner_s4 == CORNER_BR);
	assign vertex.vertex_color = color_s4;
	assign vertex.corner_index = corner_s4;
	assign vertex.last_corner  = (corner_s4 == CORNER_TL);

endmodule

`default_nettype wire

/* sv/sprite_quad_vertex_transform.sv */
// Sprite quad corner generator.
// sprite: one sprite description per item (valid/ready). A disabled sprite is
//   taken and dropped, giving no corners.
// vertex: four corner items per enabled sprite, bottom-left, bottom-right,
//   top-right, top-left, with last_corner set on the fourth.
// cfg: camera_x (index 0) and camera_y (index 1), always ready; write only
//   while no sprite is in flight.
// The first corner passes the front's two holding stages and then the
//   corner pipeline stages s1 to s4 before it is valid.
// The single corner issue port feeds the four-stage corner pipeline one
//   corner per cycle while the receiver keeps ready high. The next sprite is
//   taken while the current one still issues corners.
// Reset clears all valid bits and both camera registers to zero.
// A receiver stall freezes the corner pipeline in place; the sprite side keeps
//   taking items until its two holding stages are full.
`default_nettype none

module sprite_quad_vertex_transform import sqvt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	sqvt_cfg_if.sink      cfg,
	sqvt_sprite_if.sink   sprite,
	sqvt_vertex_if.source vertex
);

	logic signed [31:0] camera_x_q;
	logic signed [31:0] camera_y_q;
	camera_t            camera;
	logic               issue_valid;
	logic               issue_ready;
	corner_req_t        issue;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			camera_x_q <= '0;
			camera_y_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_CAMERA_X: camera_x_q <= cfg.data;
				REG_CAMERA_Y: camera_y_q <= cfg.data;
			endcase
		end
	end

	assign camera.x = camera_x_q;
	assign camera.y = camera_y_q;

	sqvt_sprite_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.sprite      (sprite),
		.camera      (camera),
		.issue_valid (issue_valid),
		.issue_ready (issue_ready),
		.issue       (issue)
	);

	sqvt_corner_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue_valid (issue_valid),
		.issue_ready (issue_ready),
		.issue       (issue),
		.vertex      (vertex)
	);

`ifndef NO_ASSERTIONS
	assert property (@(posedge clk) disable iff (!arst_n)
		(issue_valid && issue_ready && issue.corner != CORNER_TL)
		|=> (issue_valid && (issue.corner - $past(issue.corner) == 2'd1)))
		else $error("corner issue skipped or repeated a corner");

	assert property (@(posedge clk) disable iff (!arst_n)
		vertex.valid |-> (vertex.last_corner == (vertex.corner_index == CORNER_TL)))
		else $error("last_corner does not match the top-left corner");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cfg.valid && cfg.ready && cfg_reg_t'(cfg.index) == REG_CAMERA_X)
		|=> (camera_x_q == $past(cfg.data)))
		else $error("camera_x write lost");
`endif

endmodule

`default_nettype wire
